[hdl/sorted_uid_table_top_defines.svh]
// Assertion macros shared by the sorted id table RTL.
`ifndef SORTED_UID_TABLE_TOP_DEFINES_SVH
`define SORTED_UID_TABLE_TOP_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define SUT_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("sorted uid table assertion failed");
// Property whose consequent must hold in the cycle after the antecedent.
`define SUT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted uid table assertion failed");
`else
`define SUT_ASSERT(lbl, clk, rst_n, expr)
`define SUT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hdl/sut_pkg.sv]
// Shared types and constants of the sorted id table.
`default_nettype none

package sut_pkg;

	// Fixed widths of the command and result fields.
	localparam int CMD_W   = 2;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 2'd0,
		CMD_DEL   = 2'd1,
		CMD_FIND  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_EXHAUSTED = 2'd3
	} status_t;

	// Update command broadcast from the controller to every cell.
	typedef struct packed {
		logic add;
		logic del;
	} cell_op_t;

endpackage

`default_nettype wire

[hdl/sut_cell.sv]
// One table cell: holds one id and handle, compares against the key, shifts down on delete.
`default_nettype none

module sut_cell #(
	parameter int ID_WIDTH     = 16,
	parameter int HANDLE_WIDTH = 16,
	parameter int CNT_W        = 7,
	parameter int INDEX        = 0
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire sut_pkg::cell_op_t       op,
	input  wire logic [CNT_W-1:0]        used,
	input  wire logic [ID_WIDTH-1:0]     key,
	input  wire logic [ID_WIDTH-1:0]     new_id,
	input  wire logic [HANDLE_WIDTH-1:0] new_handle,
	input  wire logic [ID_WIDTH-1:0]     up_id,
	input  wire logic [HANDLE_WIDTH-1:0] up_handle,
	output logic [ID_WIDTH-1:0]          id,
	output logic [HANDLE_WIDTH-1:0]      handle,
	output logic                         match
);
	import sut_pkg::*;

	logic [ID_WIDTH-1:0]     id_q;
	logic [HANDLE_WIDTH-1:0] handle_q;
	logic                    match_q;
	logic                    ge_q;
	logic                    occupied;
	logic                    at_tail;

	// The cell holds a live entry when its index lies below the fill count.
	assign occupied = CNT_W'(INDEX) < used;
	assign at_tail  = CNT_W'(INDEX) == used;

	// Compare flags, refreshed every cycle from the broadcast key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			ge_q    <= 1'b0;
		end else begin
			match_q <= occupied && (id_q == key);
			ge_q    <= occupied && (id_q >= key);
		end
	end

	// An add writes the cell just past the last entry; a delete pulls every
	// entry at or above the hit one place down from the upper neighbor.
	always_ff @(posedge clk) begin
		if (op.add && at_tail) begin
			id_q     <= new_id;
			handle_q <= new_handle;
		end else if (op.del && ge_q) begin
			id_q     <= up_id;
			handle_q <= up_handle;
		end
	end

	assign id     = id_q;
	assign handle = handle_q;
	assign match  = match_q;

endmodule

`default_nettype wire

[hdl/sut_ctrl.sv]
// Command sequencer: input and output handshakes, fill count, id counter and result register.
`default_nettype none

`include "sorted_uid_table_top_defines.svh"

module sut_ctrl #(
	parameter int DEPTH        = 64,
	parameter int ID_WIDTH     = 16,
	parameter int HANDLE_WIDTH = 16,
	parameter int IDX_W        = 6,
	parameter int CNT_W        = 7
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [sut_pkg::CMD_W-1:0]     cmd,
	input  wire logic [ID_WIDTH-1:0]           key_uid,
	input  wire logic [HANDLE_WIDTH-1:0]       payload,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output sut_pkg::status_t                   status,
	output logic [sut_pkg::POS_W-1:0]          position,
	output logic [ID_WIDTH-1:0]                uid_out,
	output logic [HANDLE_WIDTH-1:0]            payload_out,
	output logic [sut_pkg::COUNT_W-1:0]        entry_count,
	input  wire logic                          hit_found,
	input  wire logic [IDX_W-1:0]              hit_pos,
	input  wire logic [ID_WIDTH-1:0]           hit_id,
	input  wire logic [HANDLE_WIDTH-1:0]       hit_handle,
	output sut_pkg::cell_op_t                  cell_op,
	output logic [CNT_W-1:0]                   used,
	output logic [ID_WIDTH-1:0]                key,
	output logic [ID_WIDTH-1:0]                new_id,
	output logic [HANDLE_WIDTH-1:0]            new_handle
);
	import sut_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t                  state_q;
	cmd_t                    cmd_q;
	logic [ID_WIDTH-1:0]     key_q;
	logic [HANDLE_WIDTH-1:0] payload_q;
	logic [CNT_W-1:0]        used_q;
	logic [ID_WIDTH:0]       next_id_q;

	logic                    out_valid_q;
	status_t                 status_q;
	logic [POS_W-1:0]        position_q;
	logic [ID_WIDTH-1:0]     uid_q;
	logic [HANDLE_WIDTH-1:0] handle_out_q;
	logic [COUNT_W-1:0]      count_q;

	logic                    resp_go;
	cell_op_t                op_c;
	status_t                 res_status;
	logic [IDX_W-1:0]        res_pos;
	logic [ID_WIDTH-1:0]     res_uid;
	logic [HANDLE_WIDTH-1:0] res_handle;
	logic [CNT_W-1:0]        used_nxt;
	logic [ID_WIDTH:0]       next_id_nxt;
	logic [31:0]             pos_wide;
	logic [31:0]             count_wide;

	assign in_ready = state_q == ST_IDLE;
	// The result slot is free when empty or being drained in this cycle.
	assign resp_go  = (state_q == ST_RESP) && (!out_valid_q || out_ready);

	// Work out the result and the state update of the held command.
	always_comb begin
		op_c        = '0;
		res_status  = STAT_OK;
		res_pos     = '0;
		res_uid     = '0;
		res_handle  = '0;
		used_nxt    = used_q;
		next_id_nxt = next_id_q;
		unique case (cmd_q)
			CMD_ADD: begin
				if (used_q == CNT_W'(DEPTH)) begin
					res_status = STAT_FULL;
				end else if (next_id_q[ID_WIDTH]) begin
					res_status = STAT_EXHAUSTED;
				end else begin
					op_c.add    = 1'b1;
					res_pos     = used_q[IDX_W-1:0];
					res_uid     = next_id_q[ID_WIDTH-1:0];
					used_nxt    = used_q + CNT_W'(1);
					next_id_nxt = next_id_q + (ID_WIDTH+1)'(1);
				end
			end
			CMD_DEL, CMD_FIND: begin
				if (!hit_found) begin
					res_status = STAT_NOT_FOUND;
				end else begin
					res_pos    = hit_pos;
					res_uid    = hit_id;
					res_handle = hit_handle;
					if (cmd_q == CMD_DEL) begin
						op_c.del = 1'b1;
						used_nxt = used_q - CNT_W'(1);
					end
				end
			end
			CMD_CLEAR: begin
				used_nxt = '0;
			end
			default: begin
				res_status = STAT_OK;
			end
		endcase
	end

	assign pos_wide   = 32'(res_pos);
	assign count_wide = 32'(used_nxt);

	// Sequencer and architectural counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			next_id_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (resp_go) begin
						state_q   <= ST_IDLE;
						used_q    <= used_nxt;
						next_id_q <= next_id_nxt;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command fields captured on the input beat.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q     <= cmd_t'(cmd);
			key_q     <= key_uid;
			payload_q <= payload;
		end
	end

	// Result register: loaded when the command resolves, held until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_go) begin
			status_q     <= res_status;
			position_q   <= pos_wide[POS_W-1:0];
			uid_q        <= res_uid;
			handle_out_q <= res_handle;
			count_q      <= count_wide[COUNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign uid_out     = uid_q;
	assign payload_out = handle_out_q;
	assign entry_count = count_q;

	assign cell_op    = resp_go ? op_c : '0;
	assign used       = used_q;
	assign key        = key_q;
	assign new_id     = next_id_q[ID_WIDTH-1:0];
	assign new_handle = payload_q;

	// Checks on the sequencer and counters.
	`SUT_ASSERT(a_used_bound, clk, arst_n, used_q <= CNT_W'(DEPTH))
	`SUT_IMPLY(a_accept_to_cmp, clk, arst_n, in_valid && in_ready, state_q == ST_CMP)
	`SUT_ASSERT(a_id_monotonic, clk, arst_n, next_id_q >= $past(next_id_q))
	`SUT_IMPLY(a_resp_loads_out, clk, arst_n, resp_go, out_valid_q && state_q == ST_IDLE)

endmodule

`default_nettype wire

[hdl/sorted_uid_table_top.sv]
// Top level of the sorted id table: a chain of entry cells and the command sequencer.
`default_nettype none

// Sorted id table. A command goes through these steps from the input beat to a
// loaded result: the command is captured, every cell compares its id with the
// key and registers the outcome, and then the cell outcomes are merged, the chain
// is updated and the result register is written. A new command is taken as soon
// as the sequencer is back in idle, so commands are handled one at a time; a
// pending result only stalls the sequencer when the next command is ready to
// resolve. Entries are one per cell; a delete shifts all later entries down by
// one in the same cycle, with each cell loading from its upper neighbor.
module sorted_uid_table_top #(
	parameter int DEPTH        = 64,
	parameter int ID_WIDTH     = 16,
	parameter int HANDLE_WIDTH = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [sut_pkg::CMD_W-1:0] cmd,
	input  wire logic [ID_WIDTH-1:0]       key_uid,
	input  wire logic [HANDLE_WIDTH-1:0]   payload,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output sut_pkg::status_t               status,
	output logic [sut_pkg::POS_W-1:0]      position,
	output logic [ID_WIDTH-1:0]            uid_out,
	output logic [HANDLE_WIDTH-1:0]        payload_out,
	output logic [sut_pkg::COUNT_W-1:0]    entry_count
);
	import sut_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cell_op_t                cell_op;
	logic [CNT_W-1:0]        used;
	logic [ID_WIDTH-1:0]     key;
	logic [ID_WIDTH-1:0]     new_id;
	logic [HANDLE_WIDTH-1:0] new_handle;

	logic [ID_WIDTH-1:0]     cell_id     [DEPTH];
	logic [HANDLE_WIDTH-1:0] cell_handle [DEPTH];
	logic [DEPTH-1:0]        cell_match;

	logic                    hit_found;
	logic [IDX_W-1:0]        hit_pos;
	logic [ID_WIDTH-1:0]     hit_id;
	logic [HANDLE_WIDTH-1:0] hit_handle;

	// Chain of cells; the top cell reloads itself on a delete.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int UP = (i < DEPTH - 1) ? i + 1 : i;

		sut_cell #(
			.ID_WIDTH    (ID_WIDTH),
			.HANDLE_WIDTH(HANDLE_WIDTH),
			.CNT_W       (CNT_W),
			.INDEX       (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (cell_op),
			.used      (used),
			.key       (key),
			.new_id    (new_id),
			.new_handle(new_handle),
			.up_id     (cell_id[UP]),
			.up_handle (cell_handle[UP]),
			.id        (cell_id[i]),
			.handle    (cell_handle[i]),
			.match     (cell_match[i])
		);
	end

	// Ids are unique, so at most one cell matches and an OR merge suffices.
	always_comb begin
		hit_found  = 1'b0;
		hit_pos    = '0;
		hit_id     = '0;
		hit_handle = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cell_match[i]) begin
				hit_found  = 1'b1;
				hit_pos    = hit_pos | IDX_W'(i);
				hit_id     = hit_id | cell_id[i];
				hit_handle = hit_handle | cell_handle[i];
			end
		end
	end

	sut_ctrl #(
		.DEPTH       (DEPTH),
		.ID_WIDTH    (ID_WIDTH),
		.HANDLE_WIDTH(HANDLE_WIDTH),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.key_uid    (key_uid),
		.payload    (payload),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.position   (position),
		.uid_out    (uid_out),
		.payload_out(payload_out),
		.entry_count(entry_count),
		.hit_found  (hit_found),
		.hit_pos    (hit_pos),
		.hit_id     (hit_id),
		.hit_handle (hit_handle),
		.cell_op    (cell_op),
		.used       (used),
		.key        (key),
		.new_id     (new_id),
		.new_handle (new_handle)
	);

endmodule

`default_nettype wire

[tb/sorted_uid_table_checker.sv]
// Result checker for the sorted id table: predicts each reply and compares it field by field.
module sorted_uid_table_checker #(
	parameter int DEPTH        = 64,
	parameter int ID_WIDTH     = 16,
	parameter int HANDLE_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [sut_pkg::CMD_W-1:0]    cmd,
	input  logic [ID_WIDTH-1:0]          key_uid,
	input  logic [HANDLE_WIDTH-1:0]      payload,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  sut_pkg::status_t             status,
	input  logic [sut_pkg::POS_W-1:0]    position,
	input  logic [ID_WIDTH-1:0]          uid_out,
	input  logic [HANDLE_WIDTH-1:0]      payload_out,
	input  logic [sut_pkg::COUNT_W-1:0]  entry_count,
	output int                           mismatches,
	output int                           outstanding
);
	import sut_pkg::*;

	typedef struct packed {
		status_t                 status;
		logic [POS_W-1:0]        position;
		logic [ID_WIDTH-1:0]     uid;
		logic [HANDLE_WIDTH-1:0] handle;
		logic [COUNT_W-1:0]      count;
	} table_reply_t;

	// Mirror of the table contents, kept in ascending id order.
	logic [ID_WIDTH-1:0]     mirror_ids [DEPTH];
	logic [HANDLE_WIDTH-1:0] mirror_handles [DEPTH];
	int                      live_count;
	logic [ID_WIDTH:0]       id_counter;
	table_reply_t            replies_due [$];
	table_reply_t            want;

	// Binary search over the occupied part of the mirror.
	function automatic bit locate_id(input logic [ID_WIDTH-1:0] key, output int slot);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = live_count;
		slot = 0;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (mirror_ids[mid] == key) begin
				slot = mid;
				return 1'b1;
			end
			if (mirror_ids[mid] < key)
				lo = mid + 1;
			else
				hi = mid;
		end
		return 1'b0;
	endfunction

	// Applies one command to the mirror and returns the reply it must produce.
	function automatic table_reply_t apply_table_op(input cmd_t op,
			input logic [ID_WIDTH-1:0] key, input logic [HANDLE_WIDTH-1:0] handle);
		table_reply_t r;
		int slot;
		r = '0;
		r.status = STAT_OK;
		case (op)
			CMD_ADD: begin
				// A full table is reported ahead of a spent id counter.
				if (live_count >= DEPTH) begin
					r.status = STAT_FULL;
				end else if (id_counter >= (1 << ID_WIDTH)) begin
					r.status = STAT_EXHAUSTED;
				end else begin
					mirror_ids[live_count] = id_counter[ID_WIDTH-1:0];
					mirror_handles[live_count] = handle;
					r.position = POS_W'(live_count);
					r.uid = id_counter[ID_WIDTH-1:0];
					live_count++;
					id_counter++;
				end
			end
			CMD_DEL, CMD_FIND: begin
				if (!locate_id(key, slot)) begin
					r.status = STAT_NOT_FOUND;
				end else begin
					r.position = POS_W'(slot);
					r.uid = mirror_ids[slot];
					r.handle = mirror_handles[slot];
					// Removal closes the gap by moving later entries down one place.
					if (op == CMD_DEL) begin
						for (int i = slot; i < live_count - 1; i++) begin
							mirror_ids[i] = mirror_ids[i + 1];
							mirror_handles[i] = mirror_handles[i + 1];
						end
						live_count--;
					end
				end
			end
			default: begin
				live_count = 0;
			end
		endcase
		r.count = COUNT_W'(live_count);
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
			mismatches++;
		end
	endtask

	// Result beats are checked against the oldest prediction; command beats add one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_count = 0;
			id_counter = '0;
			replies_due.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: result beat with no command pending, %s %0d uid %0h",
						$time, "expected none, actual status", status, uid_out);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					compare_field("status", want.status, status);
					compare_field("position", want.position, position);
					compare_field("uid_out", want.uid, uid_out);
					compare_field("payload_out", want.handle, payload_out);
					compare_field("entry_count", want.count, entry_count);
				end
			end
			if (in_valid && in_ready)
				replies_due.insert(replies_due.size(),
					apply_table_op(cmd_t'(cmd), key_uid, payload));
			outstanding = replies_due.size();
		end
	end

endmodule

[tb/tb_top.sv]
// Testbench top for the sorted id table: clock, reset, command stimulus and the verdict.
module tb_top;
	import sut_pkg::*;

	localparam int DEPTH        = 64;
	localparam int ID_WIDTH     = 16;
	localparam int HANDLE_WIDTH = 16;
	localparam int ID_LIMIT     = 1 << ID_WIDTH;
	localparam int LONG_HOLD    = 250;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [CMD_W-1:0]        cmd;
	logic [ID_WIDTH-1:0]     key_uid;
	logic [HANDLE_WIDTH-1:0] payload;
	logic                    out_valid;
	logic                    out_ready;
	status_t                 status;
	logic [POS_W-1:0]        position;
	logic [ID_WIDTH-1:0]     uid_out;
	logic [HANDLE_WIDTH-1:0] payload_out;
	logic [COUNT_W-1:0]      entry_count;
	int                      mismatches;
	int                      outstanding;

	// Idle rates per phase and the request for one long receiver hold-off.
	int snd_idle_pct;
	int rcv_idle_pct;
	bit hold_request;
	bit hold_taken;
	int hold_left;
	int drain_wait;

	// Ids the stimulus believes are live, used to aim finds and deletes.
	int live_ids [$];
	int ids_issued;

	sorted_uid_table_top #(
		.DEPTH(DEPTH),
		.ID_WIDTH(ID_WIDTH),
		.HANDLE_WIDTH(HANDLE_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.key_uid(key_uid),
		.payload(payload),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.position(position),
		.uid_out(uid_out),
		.payload_out(payload_out),
		.entry_count(entry_count)
	);

	sorted_uid_table_checker #(
		.DEPTH(DEPTH),
		.ID_WIDTH(ID_WIDTH),
		.HANDLE_WIDTH(HANDLE_WIDTH)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.key_uid(key_uid),
		.payload(payload),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.position(position),
		.uid_out(uid_out),
		.payload_out(payload_out),
		.entry_count(entry_count),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#30000000;
		$display("== FAIL ==");
		$finish;
	end

	// Keeps the stimulus view of live ids in step with each command beat sent.
	task automatic track_table(input cmd_t op, input logic [ID_WIDTH-1:0] key);
		int hit;
		hit = -1;
		case (op)
			CMD_ADD: begin
				if (live_ids.size() < DEPTH && ids_issued < ID_LIMIT) begin
					live_ids.insert(live_ids.size(), ids_issued);
					ids_issued++;
				end
			end
			CMD_DEL: begin
				for (int i = 0; i < live_ids.size(); i++)
					if (live_ids[i] == key)
						hit = i;
				if (hit >= 0)
					live_ids.delete(hit);
			end
			CMD_CLEAR: begin
				live_ids.delete();
			end
			default: begin
			end
		endcase
	endtask

	// Offers one command beat at a falling edge and returns at the falling edge after it is taken.
	task automatic send_beat(input cmd_t op, input logic [ID_WIDTH-1:0] key,
			input logic [HANDLE_WIDTH-1:0] handle);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		key_uid <= key;
		payload <= handle;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		track_table(op, key);
	endtask

	// Holds the command channel quiet until every reply has been taken.
	task automatic wait_for_replies();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
	endtask

	// Mostly live ids, some just past or just before the counter, and some arbitrary ones.
	function automatic logic [ID_WIDTH-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (live_ids.size() > 0 && r < 65)
			return ID_WIDTH'(live_ids[$urandom_range(live_ids.size() - 1)]);
		if (r < 75)
			return ID_WIDTH'(ids_issued - ((ids_issued > 3) ? $urandom_range(3) : 0));
		if (r < 82)
			return $urandom_range(1) ? {ID_WIDTH{1'b1}} : '0;
		return ID_WIDTH'($urandom);
	endfunction

	// Random commands in episodes that fill, grow, shrink or churn the table.
	task automatic random_commands(input int count);
		int done;
		int span;
		int add_w;
		int del_w;
		int find_w;
		int r;
		cmd_t op;
		done = 0;
		while (done < count) begin
			case ($urandom_range(3))
				0: begin add_w = 90; del_w = 3;  find_w = 7;  end
				1: begin add_w = 60; del_w = 15; find_w = 23; end
				2: begin add_w = 15; del_w = 50; find_w = 30; end
				default: begin add_w = 35; del_w = 30; find_w = 30; end
			endcase
			span = $urandom_range(10, 80);
			while (span > 0 && done < count) begin
				r = $urandom_range(99);
				if (r < add_w)
					op = CMD_ADD;
				else if (r < add_w + del_w)
					op = CMD_DEL;
				else if (r < add_w + del_w + find_w)
					op = CMD_FIND;
				else
					op = CMD_CLEAR;
				send_beat(op, (op == CMD_DEL || op == CMD_FIND) ? pick_key() : ID_WIDTH'($urandom),
					HANDLE_WIDTH'($urandom));
				span--;
				done++;
			end
		end
	endtask

	// Fills every place of the table, probes the full table at both ends, then removes, refills and clears it.
	task automatic fill_table();
		send_beat(CMD_CLEAR, ID_WIDTH'($urandom), HANDLE_WIDTH'($urandom));
		repeat (DEPTH)
			send_beat(CMD_ADD, ID_WIDTH'($urandom), HANDLE_WIDTH'($urandom));
		// Adds against a full table leave it unchanged.
		send_beat(CMD_ADD, '0, 16'hFFFF);
		send_beat(CMD_ADD, 16'hFFFF, 16'h0001);
		send_beat(CMD_FIND, ID_WIDTH'(live_ids[DEPTH-1]), '0);
		send_beat(CMD_FIND, ID_WIDTH'(live_ids[0]), '0);
		// Removal from the last place, a refill, then removal from the middle.
		send_beat(CMD_DEL, ID_WIDTH'(live_ids[DEPTH-1]), '0);
		send_beat(CMD_ADD, '0, 16'h1357);
		send_beat(CMD_DEL, ID_WIDTH'(live_ids[DEPTH/2]), '0);
		send_beat(CMD_FIND, ID_WIDTH'(live_ids[DEPTH/2]), '0);
		send_beat(CMD_ADD, 16'hFFFF, 16'h2468);
		send_beat(CMD_FIND, 16'hFFFF, '0);
		send_beat(CMD_CLEAR, '0, '0);
		send_beat(CMD_ADD, '0, 16'hFFFF);
		send_beat(CMD_FIND, ID_WIDTH'(ids_issued - 1), '0);
	endtask

	// Receiver side: random back-pressure, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n) begin
				if (hold_left == 0 && hold_request && !hold_taken) begin
					hold_left = LONG_HOLD;
					hold_taken = 1'b1;
				end
				if (hold_left > 0) begin
					hold_left--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= ($urandom_range(99) >= rcv_idle_pct);
				end
			end
		end
	end

	// Command stimulus and verdict.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_ADD;
		key_uid = '0;
		payload = '0;
		hold_request = 1'b0;
		ids_issued = 0;
		snd_idle_pct = 11;
		rcv_idle_pct = 48;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty table, field extremes, and removal at first, middle and last place.
		send_beat(CMD_FIND, '0, '0);
		send_beat(CMD_DEL, 16'hFFFF, 16'hFFFF);
		send_beat(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
		send_beat(CMD_ADD, 16'hFFFF, 16'h0000);
		send_beat(CMD_ADD, '0, 16'hFFFF);
		send_beat(CMD_ADD, 16'h5555, 16'h5555);
		send_beat(CMD_ADD, 16'hAAAA, 16'hAAAA);
		send_beat(CMD_ADD, '0, 16'h1234);
		send_beat(CMD_FIND, 16'd0, '0);
		send_beat(CMD_FIND, 16'd2, 16'hFFFF);
		send_beat(CMD_FIND, 16'd4, '0);
		send_beat(CMD_FIND, 16'hFFFF, '0);
		send_beat(CMD_FIND, 16'd5, '0);
		send_beat(CMD_DEL, 16'd2, '0);
		send_beat(CMD_FIND, 16'd3, '0);
		send_beat(CMD_DEL, 16'd0, '0);
		send_beat(CMD_DEL, 16'd4, '0);
		send_beat(CMD_FIND, 16'd2, '0);
		send_beat(CMD_DEL, 16'd2, '0);
		send_beat(CMD_ADD, '0, 16'h00FF);
		send_beat(CMD_CLEAR, '0, '0);
		send_beat(CMD_FIND, 16'd1, '0);
		send_beat(CMD_ADD, '0, 16'hFF00);
		send_beat(CMD_FIND, 16'd6, '0);

		// Receiver stalling nearly half the time; one long hold fills the block, then a full drain.
		random_commands(100);
		hold_request = 1'b1;
		random_commands(60);
		wait_for_replies();
		random_commands(350);

		// Sender idle nearly half the time.
		snd_idle_pct = 48;
		rcv_idle_pct = 11;
		random_commands(470);

		// Neither side idles.
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		random_commands(470);
		fill_table();

		in_valid <= 1'b0;
		drain_wait = 0;
		do begin
			@(negedge clk);
			drain_wait++;
		end while (outstanding != 0 && drain_wait < 2000);
		repeat (10) @(negedge clk);

		if (outstanding != 0)
			$display("%0t: %0d replies never arrived", $time, outstanding);
		if (mismatches == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
